### hw/rtl/pee_pkg.sv
// Shared constants, character codes and sequencer states for the postfix evaluator.
// No dependencies; imported by pee_ram users and the top level.
package pee_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);
  localparam int unsigned OUT_W       = 40;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_POP_A,
    ST_GET_A,
    ST_POP_B,
    ST_GET_B,
    ST_EXEC,
    ST_DIV,
    ST_DIV_END,
    ST_PUSH_OP,
    ST_FINISH,
    ST_RESULT
  } state_e;

endpackage

### hw/rtl/pee_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pee_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hw/rtl/postfix_expression_evaluator_unit.sv
// Postfix (RPN) expression evaluator: operand stack in pee_ram, iterative sequencer.
// Depends on pee_pkg and pee_ram.
//
//  channel   dir  tdata                                   tuser  tlast
//  s_axis    in   [7:0] char_in                           -      is_last
//  m_axis    out  [31:0] result_value, [32] underflow,    -      -
//                 [33] div_zero, [34] overflow
//
// Digits accumulate; any other character, or a last digit, pushes the open number. An operator
// pops two operands, executes and pushes; unknown ones push zero. Division uses a restoring
// divider, one quotient bit per cycle; a zero divisor skips it. An empty pop reads zero.
// The result register holds until taken; input is accepted meanwhile, and the next
// result stalls the sequencer until the register is free.
// Reset empties the stack and clears number, flags and result register.
module postfix_expression_evaluator_unit
  import pee_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] char_in
  input  logic             s_axis_tlast,   // is_last
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // [31:0] result_value, [32] underflow_seen,
                                           // [33] div_zero_seen, [34] overflow_seen
);

  state_e               state_q, state_d;
  logic [7:0]           char_q, char_d;
  logic                 last_q, last_d;
  logic [DATA_W-1:0]    acc_q, acc_d;
  logic                 innum_q, innum_d;
  logic [DEPTH_W-1:0]   depth_q, depth_d;
  logic                 uf_q, uf_d, dz_q, dz_d, of_q, of_d;
  logic [DATA_W-1:0]    a_q, a_d, b_q, b_d, res_q, res_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic                 neg_q, neg_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_W-1:0]     out_data_q, out_data_d;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [DATA_W-1:0]    ram_wdata, ram_rdata;

  logic [DEPTH_W-1:0]   depth_m1;
  logic                 empty, full, in_digit, q_digit, out_load;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      rem_sub;
  logic [DATA_W-1:0]    digit_val;

  assign depth_m1  = depth_q - DEPTH_W'(1);
  assign empty     = (depth_q == '0);
  assign full      = (depth_q == DEPTH_W'(STACK_DEPTH));
  assign in_digit  = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
  assign q_digit   = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
  assign digit_val = DATA_W'(s_axis_tdata - CH_ZERO);
  assign rem_sh    = {rem_q, b_q[DATA_W-1]};
  assign rem_sub   = rem_sh - {1'b0, a_q};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  pee_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    char_d      = char_q;
    last_d      = last_q;
    acc_d       = acc_q;
    innum_d     = innum_q;
    depth_d     = depth_q;
    uf_d        = uf_q;
    dz_d        = dz_q;
    of_d        = of_q;
    a_d         = a_q;
    b_d         = b_q;
    res_d       = res_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = depth_q[ADDR_W-1:0];
    ram_wdata   = res_q;
    ram_raddr   = depth_m1[ADDR_W-1:0];
    out_load    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          char_d = s_axis_tdata;
          last_d = s_axis_tlast;
          if (in_digit) begin
            acc_d   = (acc_q << 3) + (acc_q << 1) + digit_val;
            innum_d = 1'b1;
            state_d = s_axis_tlast ? ST_FLUSH : ST_IDLE;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (innum_q) begin
          ram_wdata = acc_q;
          if (full) begin
            of_d = 1'b1;
          end else begin
            ram_we  = 1'b1;
            depth_d = depth_q + DEPTH_W'(1);
          end
          acc_d   = '0;
          innum_d = 1'b0;
        end
        if (q_digit || char_q == CH_COMMA) begin
          state_d = last_q ? ST_FINISH : ST_IDLE;
        end else begin
          state_d = ST_POP_A;
        end
      end
      ST_POP_A: begin
        if (empty) begin
          a_d     = '0;
          uf_d    = 1'b1;
          state_d = ST_POP_B;
        end else begin
          ram_re  = 1'b1;
          depth_d = depth_m1;
          state_d = ST_GET_A;
        end
      end
      ST_GET_A: begin
        a_d     = ram_rdata;
        state_d = ST_POP_B;
      end
      ST_POP_B: begin
        if (empty) begin
          b_d     = '0;
          uf_d    = 1'b1;
          state_d = ST_EXEC;
        end else begin
          ram_re  = 1'b1;
          depth_d = depth_m1;
          state_d = ST_GET_B;
        end
      end
      ST_GET_B: begin
        b_d     = ram_rdata;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_PUSH_OP;
        case (char_q)
          CH_PLUS:  res_d = b_q + a_q;
          CH_MINUS: res_d = b_q - a_q;
          CH_STAR:  res_d = b_q * a_q;
          CH_SLASH: begin
            if (a_q == '0) begin
              dz_d  = 1'b1;
              res_d = '0;
            end else begin
              a_d     = a_q[DATA_W-1] ? -a_q : a_q;
              b_d     = b_q[DATA_W-1] ? -b_q : b_q;
              neg_d   = a_q[DATA_W-1] ^ b_q[DATA_W-1];
              rem_d   = '0;
              cnt_d   = '0;
              state_d = ST_DIV;
            end
          end
          default:  res_d = '0;
        endcase
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, a_q}) begin
          rem_d = rem_sub[DATA_W-1:0];
          b_d   = {b_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DATA_W-1:0];
          b_d   = {b_q[DATA_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == '1) begin
          state_d = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        res_d   = neg_q ? -b_q : b_q;
        state_d = ST_PUSH_OP;
      end
      ST_PUSH_OP: begin
        if (full) begin
          of_d = 1'b1;
        end else begin
          ram_we  = 1'b1;
          depth_d = depth_q + DEPTH_W'(1);
        end
        state_d = last_q ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        ram_re  = !empty;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          depth_d  = '0;
          acc_d    = '0;
          innum_d  = 1'b0;
          uf_d     = 1'b0;
          dz_d     = 1'b0;
          of_d     = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {{(OUT_W - DATA_W - 3){1'b0}}, of_q, dz_q, uf_q,
                     (empty ? {DATA_W{1'b0}} : ram_rdata)};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      char_q      <= '0;
      last_q      <= 1'b0;
      acc_q       <= '0;
      innum_q     <= 1'b0;
      depth_q     <= '0;
      uf_q        <= 1'b0;
      dz_q        <= 1'b0;
      of_q        <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      res_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      char_q      <= char_d;
      last_q      <= last_d;
      acc_q       <= acc_d;
      innum_q     <= innum_d;
      depth_q     <= depth_d;
      uf_q        <= uf_d;
      dz_q        <= dz_d;
      of_q        <= of_d;
      a_q         <= a_d;
      b_q         <= b_d;
      res_q       <= res_d;
      rem_q       <= rem_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !full)
    else $error("stack write while full");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (a_q != '0))
    else $error("divider running with zero divisor");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (depth_q == '0) && !innum_q && !uf_q && !dz_q && !of_q
                 && out_valid_q)
    else $error("state not cleared after result");
`endif

endmodule

### verif/postfix_expression_evaluator_unit_test.sv
// Self-checking testbench for postfix_expression_evaluator_unit: directed and random expressions.
// Predicts results with an operand stack model or fixed directed values; checks every output.
// Depends on pee_pkg and the unit under test only.
`timescale 1ns / 100ps

module postfix_expression_evaluator_unit_test
  import pee_pkg::*;
();

  localparam int          CYCLE_LIMIT = 800_000;
  localparam int          CHAR_TARGET = 1100;
  localparam int          DRAIN_WAIT  = 100;
  localparam int          SQUEEZE_LEN = 3000;
  localparam logic [7:0]  CH_NUL      = 8'h00;
  localparam logic [7:0]  CH_TOP      = 8'hFF;

  typedef struct packed {
    logic        of;
    logic        dz;
    logic        uf;
    logic [31:0] val;
  } rpn_res_t;

  typedef struct {
    logic [7:0] chr;
    bit         lst;
    bit         fixed;
    rpn_res_t   res;
  } dir_row_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  postfix_expression_evaluator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // operand stack model
  logic [31:0] opnd_mem [STACK_DEPTH];
  int unsigned opnd_cnt = 0;
  logic [31:0] num_acc  = '0;
  bit          num_open = 1'b0;
  bit          flag_uf  = 1'b0;
  bit          flag_dz  = 1'b0;
  bit          flag_of  = 1'b0;

  rpn_res_t    result_q [$];
  logic [7:0]  expr_buf [$];
  int          chars_sent   = 0;
  int          res_seen     = 0;
  int          err_cnt      = 0;
  int          cyc_cnt      = 0;
  bit          squeeze_done = 1'b0;
  rpn_res_t    exp_res;

  dir_row_t dir_tab [0:25] = '{
    '{CH_COMMA,           1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0}},
    '{CH_PLUS,            1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 32'd0}},
    '{CH_NINE,            1'b0, 1'b0, '0},
    '{CH_COMMA,           1'b0, 1'b0, '0},
    '{CH_ZERO,            1'b0, 1'b0, '0},
    '{CH_SLASH,           1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 32'd0}},
    '{CH_TOP,             1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 32'd0}},
    '{CH_ZERO + 8'd5,     1'b0, 1'b0, '0},
    '{CH_NUL,             1'b1, 1'b0, '0},
    '{CH_ZERO + 8'd1,     1'b0, 1'b0, '0},
    '{CH_COMMA,           1'b0, 1'b0, '0},
    '{CH_ZERO + 8'd8,     1'b0, 1'b0, '0},
    '{CH_MINUS,           1'b0, 1'b0, '0},
    '{CH_ZERO + 8'd3,     1'b0, 1'b0, '0},
    '{CH_SLASH,           1'b1, 1'b0, '0},
    '{CH_ZERO + 8'd6,     1'b0, 1'b0, '0},
    '{CH_COMMA,           1'b0, 1'b0, '0},
    '{CH_ZERO + 8'd7,     1'b0, 1'b0, '0},
    '{CH_STAR,            1'b1, 1'b0, '0},
    '{CH_ZERO + 8'd4,     1'b0, 1'b0, '0},
    '{CH_ZERO + 8'd2,     1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd42}},
    '{CH_ZERO + 8'd1,     1'b0, 1'b0, '0},
    '{CH_COMMA,           1'b0, 1'b0, '0},
    '{CH_ZERO + 8'd2,     1'b0, 1'b0, '0},
    '{CH_PLUS,            1'b0, 1'b0, '0},
    '{CH_COMMA,           1'b1, 1'b0, '0}
  };

  function automatic bit is_digit(input logic [7:0] chr);
    return chr >= CH_ZERO && chr <= CH_NINE;
  endfunction

  function automatic void opnd_push(input logic [31:0] v);
    if (opnd_cnt >= STACK_DEPTH) begin
      flag_of = 1'b1;
    end else begin
      opnd_mem[opnd_cnt] = v;
      opnd_cnt++;
    end
  endfunction

  function automatic logic [31:0] opnd_pop();
    if (opnd_cnt == 0) begin
      flag_uf = 1'b1;
      return '0;
    end
    opnd_cnt--;
    return opnd_mem[opnd_cnt];
  endfunction

  function automatic void flush_num();
    if (num_open) begin
      opnd_push(num_acc);
      num_acc  = '0;
      num_open = 1'b0;
    end
  endfunction

  task automatic rpn_step(input logic [7:0] chr, input bit lst, output bit has_res,
                          output rpn_res_t res);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] v;
    longint      sa;
    longint      sb;
    has_res = 1'b0;
    res     = '0;
    v       = '0;
    if (is_digit(chr)) begin
      num_acc  = num_acc * 32'd10 + 32'(chr - CH_ZERO);
      num_open = 1'b1;
    end else begin
      flush_num();
      if (chr != CH_COMMA) begin
        a = opnd_pop();
        b = opnd_pop();
        case (chr)
          CH_PLUS:  v = b + a;
          CH_MINUS: v = b - a;
          CH_STAR:  v = b * a;
          CH_SLASH: begin
            if (a == '0) begin
              flag_dz = 1'b1;
              v = '0;
            end else begin
              sa = $signed(a);
              sb = $signed(b);
              v  = 32'(sb / sa);
            end
          end
          default:  v = '0;
        endcase
        opnd_push(v);
      end
    end
    if (lst) begin
      flush_num();
      res.val = (opnd_cnt > 0) ? opnd_mem[opnd_cnt - 1] : '0;
      res.uf  = flag_uf;
      res.dz  = flag_dz;
      res.of  = flag_of;
      has_res = 1'b1;
      opnd_cnt = 0;
      num_acc  = '0;
      num_open = 1'b0;
      flag_uf  = 1'b0;
      flag_dz  = 1'b0;
      flag_of  = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((chars_sent / 64) % 4 == 3) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_char(input logic [7:0] chr, input bit lst, input bit fixed,
                           input rpn_res_t fixed_res);
    int       gap;
    bit       has_res;
    rpn_res_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= chr;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rpn_step(chr, lst, has_res, res);
    if (has_res) result_q.push_back(fixed ? fixed_res : res);
    chars_sent++;
  endtask

  task automatic add_number();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      expr_buf.push_back(CH_ZERO);
      return;
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
    repeat (n) expr_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_operator();
    logic [7:0] chr;
    case ($urandom_range(0, 24))
      0, 1, 2, 3, 4, 5:      chr = CH_PLUS;
      6, 7, 8, 9, 10:        chr = CH_MINUS;
      11, 12, 13, 14, 15:    chr = CH_STAR;
      16, 17, 18, 19, 20, 21: chr = CH_SLASH;
      default: begin
        chr = 8'($urandom_range(0, 255));
        while (is_digit(chr) || chr == CH_COMMA || chr == CH_PLUS || chr == CH_MINUS ||
               chr == CH_STAR || chr == CH_SLASH)
          chr = 8'($urandom_range(0, 255));
      end
    endcase
    expr_buf.push_back(chr);
  endtask

  task automatic build_wellformed();
    int depth;
    int ops;
    depth = 1;
    ops   = $urandom_range(0, 5);
    add_number();
    while (ops > 0) begin
      if (depth < 2 || (depth < 6 && $urandom_range(0, 2) == 0)) begin
        if (is_digit(expr_buf[$]) || $urandom_range(0, 3) == 0) expr_buf.push_back(CH_COMMA);
        add_number();
        depth++;
      end else begin
        add_operator();
        depth--;
        ops--;
      end
    end
    if ($urandom_range(0, 19) == 0) add_operator();
    if ($urandom_range(0, 9) == 0) expr_buf.push_back(CH_COMMA);
  endtask

  task automatic build_deep();
    int n;
    n = $urandom_range(30, 36);
    repeat (n) begin
      expr_buf.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
      expr_buf.push_back(CH_COMMA);
    end
    repeat ($urandom_range(0, 3)) add_operator();
  endtask

  task automatic build_min_div();
    string most_neg;
    int    i;
    most_neg = "2147483648";
    for (i = 0; i < most_neg.len(); i++) expr_buf.push_back(most_neg[i]);
    expr_buf.push_back(CH_COMMA);
    expr_buf.push_back(CH_ZERO);
    expr_buf.push_back(CH_COMMA);
    expr_buf.push_back(CH_ZERO + 8'd1);
    expr_buf.push_back(CH_MINUS);
    expr_buf.push_back(CH_SLASH);
  endtask

  task automatic run_random_expr();
    int r;
    int i;
    expr_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 72) build_wellformed();
    else if (r < 77) build_deep();
    else if (r < 83) build_min_div();
    else repeat ($urandom_range(1, 12)) expr_buf.push_back(8'($urandom_range(0, 255)));
    for (i = 0; i < expr_buf.size(); i++)
      send_char(expr_buf[i], i == expr_buf.size() - 1, 1'b0, '0);
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < $size(dir_tab); i++)
      send_char(dir_tab[i].chr, dir_tab[i].lst, dir_tab[i].fixed, dir_tab[i].res);
    while (chars_sent < CHAR_TARGET) run_random_expr();
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[postfix_expression_evaluator_unit] OK");
    end else begin
      $display("[postfix_expression_evaluator_unit] ERROR");
    end
    $finish;
  end

  // hold off once for a long stretch so the unit backs up onto its input, else toggle ready at random
  initial begin
    int run;
    int hold;
    int r;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!squeeze_done && res_seen >= 10) begin
        squeeze_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_LEN) @(posedge clk_i);
      end
      run = $urandom_range(1, 20);
      r   = $urandom_range(0, 99);
      if (r < 40) hold = 0;
      else if (r < 85) hold = $urandom_range(1, 3);
      else hold = $urandom_range(5, 60);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  task automatic note_fail(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_seen++;
      if (result_q.size() == 0) begin
        note_fail($sformatf("unexpected result transaction: val=%h uf=%b dz=%b of=%b",
                            m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33],
                            m_axis_tdata[34]));
      end else begin
        exp_res = result_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_res.val || m_axis_tdata[32] !== exp_res.uf ||
            m_axis_tdata[33] !== exp_res.dz || m_axis_tdata[34] !== exp_res.of)
          note_fail($sformatf({"result %0d mismatch: exp val=%h uf=%b dz=%b of=%b, ",
                               "got val=%h uf=%b dz=%b of=%b"},
                              res_seen, exp_res.val, exp_res.uf, exp_res.dz, exp_res.of,
                              m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33],
                              m_axis_tdata[34]));
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc_cnt);
      $display("[postfix_expression_evaluator_unit] ERROR");
      $finish;
    end
  end

endmodule

### files.f
hw/rtl/pee_pkg.sv
hw/rtl/pee_ram.sv
hw/rtl/postfix_expression_evaluator_unit.sv
verif/postfix_expression_evaluator_unit_test.sv
